### hw/rtl/radix_integer_text_parser_defines.svh
// Assertion helpers for the parser RTL.
`ifndef RADIX_INTEGER_TEXT_PARSER_DEFINES_SVH
`define RADIX_INTEGER_TEXT_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RINTP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RINTP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/rintp_pkg.sv
package rintp_pkg;

   localparam int RADIX_W      = 6;
   localparam int CHAR_W       = 8;
   localparam int VALUE_W      = 64;
   localparam int OFFSET_OUT_W = 16;
   localparam int PHASE_W      = 3;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   // Parser phases.
   localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
   localparam logic [PHASE_W-1:0] PH_SPACE  = 3'd1;
   localparam logic [PHASE_W-1:0] PH_SIGN   = 3'd2;
   localparam logic [PHASE_W-1:0] PH_LEAD   = 3'd3;
   localparam logic [PHASE_W-1:0] PH_ZERO   = 3'd4;
   localparam logic [PHASE_W-1:0] PH_DIGITS = 3'd5;

   // Base codes.
   localparam logic [RADIX_W-1:0] BASE_AUTO  = 6'd0;
   localparam logic [RADIX_W-1:0] BASE_BAD   = 6'd1;
   localparam logic [RADIX_W-1:0] BASE_OCT   = 6'd8;
   localparam logic [RADIX_W-1:0] BASE_DEC   = 6'd10;
   localparam logic [RADIX_W-1:0] BASE_HEX   = 6'd16;
   localparam logic [RADIX_W-1:0] BASE_MAX   = 6'd36;
   localparam logic [RADIX_W-1:0] DIGIT_NONE = 6'd36;
   localparam logic [RADIX_W-1:0] LETTER_OFS = 6'd10;

   // Characters of interest.
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_A_UP  = 8'h41;
   localparam logic [CHAR_W-1:0] CH_X_UP  = 8'h58;
   localparam logic [CHAR_W-1:0] CH_Z_UP  = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_A_LO  = 8'h61;
   localparam logic [CHAR_W-1:0] CH_X_LO  = 8'h78;
   localparam logic [CHAR_W-1:0] CH_Z_LO  = 8'h7A;

   // Register index decoded from the CSR address.
   localparam logic REG_RADIX = 1'b0;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [VALUE_W-1:0] acc;
      logic [RADIX_W-1:0] base;
      logic               negative;
      logic               digit_seen;
   } parse_state_type;

   typedef struct packed {
      logic [VALUE_W-1:0]      value;
      logic [OFFSET_OUT_W-1:0] end_offset;
      logic                    has_digit;
      logic                    bad_base;
   } parse_result_type;

   // Digit value of a character in any base up to 36, DIGIT_NONE otherwise.
   function automatic logic [RADIX_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] d;
      d = '0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         d = c - CH_ZERO;
      end else if (c >= CH_A_LO && c <= CH_Z_LO) begin
         d = c - CH_A_LO + CHAR_W'(LETTER_OFS);
      end else if (c >= CH_A_UP && c <= CH_Z_UP) begin
         d = c - CH_A_UP + CHAR_W'(LETTER_OFS);
      end else begin
         d = CHAR_W'(DIGIT_NONE);
      end
      return d[RADIX_W-1:0];
   endfunction

endpackage

### hw/rtl/rintp_csr.sv
module rintp_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [rintp_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [rintp_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [rintp_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                  pready,
   output logic [rintp_pkg::RADIX_W-1:0]         radix
);
   import rintp_pkg::*;

   logic [RADIX_W-1:0] radix_ff;
   logic [RADIX_W-1:0] radix_in;
   logic               hit_radix;

   // The word index sits above the two byte-offset bits.
   assign hit_radix = (paddr[CSR_ADDR_W-1] == REG_RADIX);

   always_comb begin
      radix_in = radix_ff;
      if (psel && penable && pwrite && hit_radix) begin
         radix_in = pwdata[RADIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= BASE_AUTO;
      end else begin
         radix_ff <= radix_in;
      end
   end

   assign pready = 1'b1;
   assign prdata = hit_radix ? CSR_DATA_W'(radix_ff) : '0;
   assign radix  = radix_ff;

endmodule

### hw/rtl/rintp_step.sv
module rintp_step #(
   parameter int OFFSET_WIDTH = 16
) (
   input  rintp_pkg::parse_state_type       state_i,
   input  logic [OFFSET_WIDTH-1:0]          pos_i,
   input  logic [rintp_pkg::CHAR_W-1:0]     char_i,
   input  logic                             start_i,
   input  logic [rintp_pkg::RADIX_W-1:0]    radix_i,
   output rintp_pkg::parse_state_type       state_o,
   output logic [OFFSET_WIDTH-1:0]          pos_o,
   output logic                             emit_o,
   output rintp_pkg::parse_result_type      result_o
);
   import rintp_pkg::*;

   logic [PHASE_W-1:0]         ph;
   logic [VALUE_W-1:0]         acc;
   logic [RADIX_W-1:0]         base;
   logic                       neg;
   logic                       seen;
   logic [OFFSET_WIDTH-1:0]    pos;
   logic                       done;
   logic                       adv;
   logic [RADIX_W-1:0]         dig;
   logic [VALUE_W+RADIX_W-1:0] prod;

   always_comb begin
      ph       = state_i.phase;
      acc      = state_i.acc;
      base     = state_i.base;
      neg      = state_i.negative;
      seen     = state_i.digit_seen;
      pos      = pos_i;
      done     = 1'b0;
      adv      = 1'b0;
      emit_o   = 1'b0;
      result_o = '0;
      dig      = digit_of(char_i);
      prod     = '0;

      if (start_i) begin
         acc  = '0;
         neg  = 1'b0;
         seen = 1'b0;
         pos  = '0;
         base = radix_i;
         if (radix_i == BASE_BAD || radix_i > BASE_MAX) begin
            ph                = PH_IDLE;
            emit_o            = 1'b1;
            result_o.bad_base = 1'b1;
            done              = 1'b1;
         end else begin
            ph = PH_SPACE;
         end
      end

      if (!done && (ph == PH_IDLE || ph > PH_DIGITS)) begin
         done = 1'b1;
      end

      if (!done && ph == PH_SPACE) begin
         if (char_i == CH_SPACE || char_i == CH_TAB || char_i == CH_LF || char_i == CH_CR) begin
            adv  = 1'b1;
            done = 1'b1;
         end else begin
            ph = PH_SIGN;
         end
      end

      if (!done && ph == PH_SIGN) begin
         ph = PH_LEAD;
         if (char_i == CH_MINUS) begin
            neg  = 1'b1;
            adv  = 1'b1;
            done = 1'b1;
         end else if (char_i == CH_PLUS) begin
            adv  = 1'b1;
            done = 1'b1;
         end
      end

      if (!done && ph == PH_LEAD) begin
         if ((base == BASE_AUTO || base == BASE_HEX) && char_i == CH_ZERO) begin
            ph   = PH_ZERO;
            adv  = 1'b1;
            done = 1'b1;
         end else begin
            if (base == BASE_AUTO) begin
               base = BASE_DEC;
            end
            ph = PH_DIGITS;
         end
      end

      if (!done && ph == PH_ZERO) begin
         if (char_i == CH_X_LO || char_i == CH_X_UP) begin
            if (base == BASE_AUTO) begin
               base = BASE_HEX;
            end
            adv  = 1'b1;
            ph   = PH_DIGITS;
            done = 1'b1;
         end else begin
            // Under hex the leading zero was a real digit; under auto it
            // only picked octal.
            if (base == BASE_AUTO) begin
               base = BASE_OCT;
            end else begin
               seen = 1'b1;
            end
            ph = PH_DIGITS;
         end
      end

      if (!done) begin
         if (dig < base) begin
            prod = acc * base;
            acc  = prod[VALUE_W-1:0] + VALUE_W'(dig);
            seen = 1'b1;
            adv  = 1'b1;
         end else begin
            ph                  = PH_IDLE;
            emit_o              = 1'b1;
            result_o.value      = neg ? (VALUE_W'(0) - acc) : acc;
            result_o.end_offset = seen ? OFFSET_OUT_W'(pos) : '0;
            result_o.has_digit  = seen;
         end
      end

      if (adv && pos != '1) begin
         pos = pos + 1'b1;
      end

      state_o.phase      = ph;
      state_o.acc        = acc;
      state_o.base       = base;
      state_o.negative   = neg;
      state_o.digit_seen = seen;
      pos_o              = pos;
   end

endmodule

### hw/rtl/radix_integer_text_parser.sv
// An accepted transaction is registered in the input register, and any result it produces
// is loaded into the result register when the step logic processes that transaction.
// Throughput: one character per cycle; the per-character multiply-add by the base
// is combinational inside the step logic, so a result never blocks the stream
// unless the result register is full and the consumer stalls.
// Reset: synchronous, active high; the parser goes idle, radix returns to automatic.
`include "radix_integer_text_parser_defines.svh"

module radix_integer_text_parser #(
   parameter int OFFSET_WIDTH = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   // Character stream.
   input  logic                                       req_valid,
   output logic                                       req_ready,
   input  logic [rintp_pkg::CHAR_W-1:0]               req_character,
   input  logic                                       req_start_req,
   // Parsed numbers.
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output logic [rintp_pkg::VALUE_W-1:0]              rsp_value,
   output logic [rintp_pkg::OFFSET_OUT_W-1:0]         rsp_end_offset,
   output logic                                       rsp_has_digit,
   output logic                                       rsp_bad_base,
   // Configuration port.
   input  logic                                       psel,
   input  logic                                       penable,
   input  logic                                       pwrite,
   input  logic [rintp_pkg::CSR_ADDR_W-1:0]           paddr,
   input  logic [rintp_pkg::CSR_DATA_W-1:0]           pwdata,
   output logic [rintp_pkg::CSR_DATA_W-1:0]           prdata,
   output logic                                       pready
);
   import rintp_pkg::*;

   // Configured base. It is sampled into the parse state when a string starts,
   // so writing it mid-string only affects the next string.
   logic [RADIX_W-1:0] radix;

   rintp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .radix   (radix)
   );

   // Input register. It holds one accepted transaction until the step logic
   // consumes it; a new transaction is taken in the same cycle the held one
   // leaves, so the stream keeps moving at one character per cycle unless a result stalls.
   logic               in_valid_ff;
   logic               in_valid_in;
   logic [CHAR_W-1:0]  in_char_ff;
   logic [CHAR_W-1:0]  in_char_in;
   logic               in_start_ff;
   logic               in_start_in;

   // Parse state carried from one character to the next.
   parse_state_type         state_ff;
   parse_state_type         state_in;
   logic [OFFSET_WIDTH-1:0] pos_ff;
   logic [OFFSET_WIDTH-1:0] pos_in;

   // Result register.
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   parse_result_type rsp_data_ff;
   parse_result_type rsp_data_in;

   parse_state_type         step_state;
   logic [OFFSET_WIDTH-1:0] step_pos;
   logic                    step_emit;
   parse_result_type        step_result;
   logic                    proc_fire;
   logic                    req_fire;

   rintp_step #(
      .OFFSET_WIDTH (OFFSET_WIDTH)
   ) u_step (
      .state_i  (state_ff),
      .pos_i    (pos_ff),
      .char_i   (in_char_ff),
      .start_i  (in_start_ff),
      .radix_i  (radix),
      .state_o  (step_state),
      .pos_o    (step_pos),
      .emit_o   (step_emit),
      .result_o (step_result)
   );

   // The held character is processed when it produces no result, or when the
   // result register is empty or being drained in this cycle.
   assign proc_fire = in_valid_ff && (!step_emit || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || proc_fire;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_char_in  = in_char_ff;
      in_start_in = in_start_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_char_in  = req_character;
         in_start_in = req_start_req;
      end else if (proc_fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      if (proc_fire) begin
         state_in = step_state;
         pos_in   = step_pos;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (proc_fire && step_emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = step_result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '{phase: PH_IDLE, acc: '0, base: BASE_AUTO,
                           negative: 1'b0, digit_seen: 1'b0};
         pos_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
         pos_ff       <= pos_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      in_char_ff  <= in_char_in;
      in_start_ff <= in_start_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value      = rsp_data_ff.value;
   assign rsp_end_offset = rsp_data_ff.end_offset;
   assign rsp_has_digit  = rsp_data_ff.has_digit;
   assign rsp_bad_base   = rsp_data_ff.bad_base;

   // A bad-base result never carries a value or a digit.
   `RINTP_ASSERT_NOW(a_bad_base_clean, clock, reset,
      rsp_valid_ff && rsp_data_ff.bad_base,
      rsp_data_ff.value == '0 && !rsp_data_ff.has_digit, "bad-base result not clean")
   // Without a digit the end offset is zero.
   `RINTP_ASSERT_NOW(a_no_digit_offset, clock, reset,
      rsp_valid_ff && !rsp_data_ff.has_digit,
      rsp_data_ff.end_offset == '0, "nonzero offset without digits")
   // A held transaction that is not consumed stays in the input register.
   `RINTP_ASSERT_NEXT(a_input_kept, clock, reset,
      in_valid_ff && !proc_fire, in_valid_ff, "input transaction dropped")
   // Every emitted result leaves the parser idle.
   `RINTP_ASSERT_NEXT(a_idle_after_emit, clock, reset,
      proc_fire && step_emit, state_ff.phase == PH_IDLE && rsp_valid_ff,
      "parser not idle after result")

endmodule
